// ===== rtl/bankers_safe_allocator_unit_assert.svh =====
// assertion macros for the banker's safe allocator
`ifndef BANKERS_SAFE_ALLOCATOR_UNIT_ASSERT_SVH
`define BANKERS_SAFE_ALLOCATOR_UNIT_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define BSA_ASSERT_NOW(lbl, trig, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cond)) \
    else $error("bsa: same-cycle check failed");

// condition must hold in the cycle after the trigger
`define BSA_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error("bsa: next-cycle check failed");

`endif

// ===== rtl/bsa_pkg.sv =====
// shared types and constants of the banker's safe allocator
package bsa_pkg;

  localparam int KIND_W      = 2;
  localparam int TID_W       = 3;
  localparam int RID_W       = 2;
  localparam int AMT_W       = 4;
  localparam int STATUS_W    = 2;
  localparam int AVAIL_W     = 4;
  localparam int S_TDATA_W   = 16;
  localparam int M_TDATA_W   = 8;

  localparam int THREADS_DEF   = 8;
  localparam int RESOURCES_DEF = 4;
  localparam int UNIT_MAX_DEF  = 15;

  typedef enum logic [KIND_W-1:0] {
    KIND_SET_CAPACITY = 2'd0,
    KIND_SET_CLAIM    = 2'd1,
    KIND_REQUEST      = 2'd2,
    KIND_RELEASE      = 2'd3
  } bsa_kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_GRANTED = 2'd1,
    STATUS_DENIED  = 2'd2
  } bsa_status_e;

endpackage

// ===== rtl/bankers_safe_allocator_unit.sv =====
// Banker's-algorithm resource allocator with a deadlock-avoiding safety check.
// Input items arrive on the s_axis channel: tuser carries the kind (set capacity,
// set claim, request one unit, release all of a thread), tdata the thread, resource
// and amount. Each item yields exactly one result on m_axis: status and the
// available count of the named resource after the item.
// One item is in flight at a time; s_axis_tready_o is high only while idle.
// Set capacity, set claim and release go through the EXEC and DONE states to the output
// register, and the block is ready again in the same cycle as their result appears.
// A request that passes the precheck runs the safety scan: one thread row per
// cycle through the shared fit unit, in passes over all threads, until every
// thread has finished or a pass makes no progress.
// Reset clears the available counts and marks every claim and allocation row
// empty at once; the block is ready in the first cycle after reset.
// A finished result sits in the output register until m_axis_tready_i is high;
// the next item may be accepted meanwhile but its result waits for the slot.
`include "bankers_safe_allocator_unit_assert.svh"

module bankers_safe_allocator_unit #(
  parameter int THREADS   = bsa_pkg::THREADS_DEF,
  parameter int RESOURCES = bsa_pkg::RESOURCES_DEF,
  parameter int UNIT_MAX  = bsa_pkg::UNIT_MAX_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // thread_id [2:0], resource_id [4:3], amount [8:5], zero fill above
  input  logic [bsa_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  // kind [1:0]
  input  logic [bsa_pkg::KIND_W-1:0]     s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // status [1:0], available_after [5:2], zero fill above
  output logic [bsa_pkg::M_TDATA_W-1:0]  m_axis_tdata_o
);

  import bsa_pkg::*;

  localparam int UW  = $clog2(UNIT_MAX + 1);
  localparam int WW  = $clog2(UNIT_MAX * (THREADS + 1) + 1);
  localparam int TIW = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int RIW = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]                   state_q, state_d;
  bsa_kind_e                    kind_q;
  logic [TID_W-1:0]             tid_q;
  logic [RID_W-1:0]             rid_q;
  logic [AMT_W-1:0]             amt_q;
  logic [UW-1:0]                avail_q [RESOURCES];
  logic [UW-1:0]                avail_d [RESOURCES];
  logic [RESOURCES-1:0][WW-1:0] work_q, work_d;
  logic [RESOURCES-1:0][UW-1:0] tent_q, tent_d;
  logic [THREADS-1:0]           done_q, done_d;
  logic                         prog_q, prog_d;
  logic [TIW-1:0]               cur_q, cur_d, cur_next;
  bsa_status_e                  status_q, status_d;
  logic                         m_valid_q;
  logic [STATUS_W-1:0]          m_status_q;
  logic [AVAIL_W-1:0]           m_avail_q;

  logic                         s_acc;
  logic                         t_ok, r_ok;
  logic [TIW-1:0]               tidx;
  logic [RIW-1:0]               ridx;
  logic [UW-1:0]                amt_clamp;
  logic                         claim_we, alloc_we, alloc_clr;
  logic [TIW-1:0]               rd_addr;
  logic [RESOURCES-1:0][UW-1:0] claim_rd, alloc_rd, claim_wrow;
  logic [RESOURCES-1:0][WW-1:0] fit_work, fit_sum;
  logic [RESOURCES-1:0][UW-1:0] fit_alloc;
  logic                         fit_fits;
  logic                         fire;
  logic                         grant_w;
  logic                         load_out;

  function automatic logic [UW-1:0] clamp_sum(input logic [WW-1:0] v);
    clamp_sum = (v > WW'(UNIT_MAX)) ? UW'(UNIT_MAX) : UW'(v);
  endfunction

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  assign tidx      = TIW'(tid_q);
  assign ridx      = RIW'(rid_q);
  assign t_ok      = 32'(tid_q) < THREADS;
  assign r_ok      = 32'(rid_q) < RESOURCES;
  assign amt_clamp = (32'(amt_q) > UNIT_MAX) ? UW'(UNIT_MAX) : UW'(amt_q);

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      kind_q <= bsa_kind_e'(s_axis_tuser_i);
      tid_q  <= s_axis_tdata_i[TID_W-1:0];
      rid_q  <= s_axis_tdata_i[TID_W +: RID_W];
      amt_q  <= s_axis_tdata_i[TID_W+RID_W +: AMT_W];
    end
  end

  bsa_row_mem #(
    .THREADS   (THREADS),
    .RESOURCES (RESOURCES),
    .UW        (UW),
    .TIW       (TIW)
  ) u_claim_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (claim_we),
    .clr_en_i  (1'b0),
    .wr_addr_i (tidx),
    .wr_row_i  (claim_wrow),
    .rd_addr_i (rd_addr),
    .rd_row_o  (claim_rd)
  );

  bsa_row_mem #(
    .THREADS   (THREADS),
    .RESOURCES (RESOURCES),
    .UW        (UW),
    .TIW       (TIW)
  ) u_alloc_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (alloc_we),
    .clr_en_i  (alloc_clr),
    .wr_addr_i (tidx),
    .wr_row_i  (tent_q),
    .rd_addr_i (rd_addr),
    .rd_row_o  (alloc_rd)
  );

  // during the scan the requesting thread sees its tentative allocation
  always_comb begin
    for (int r = 0; r < RESOURCES; r++) begin
      fit_work[r] = (state_q == S_CHECK) ? work_q[r] : WW'(avail_q[r]);
    end
    fit_alloc = (state_q == S_CHECK && cur_q == tidx) ? tent_q : alloc_rd;
  end

  bsa_fit_unit #(
    .RESOURCES (RESOURCES),
    .UW        (UW),
    .WW        (WW)
  ) u_fit (
    .work_i      (fit_work),
    .claim_row_i (claim_rd),
    .alloc_row_i (fit_alloc),
    .sum_o       (fit_sum),
    .fits_o      (fit_fits)
  );

  assign cur_next = (cur_q == TIW'(THREADS - 1)) ? '0 : cur_q + TIW'(1);
  assign fire     = !done_q[cur_q] && fit_fits;

  always_comb begin
    state_d    = state_q;
    avail_d    = avail_q;
    work_d     = work_q;
    tent_d     = tent_q;
    done_d     = done_q;
    prog_d     = prog_q;
    cur_d      = cur_q;
    status_d   = status_q;
    claim_we   = 1'b0;
    alloc_we   = 1'b0;
    alloc_clr  = 1'b0;
    grant_w    = 1'b0;
    load_out   = 1'b0;
    rd_addr    = tidx;
    claim_wrow = claim_rd;
    claim_wrow[ridx] = amt_clamp;

    case (state_q)
      S_IDLE: begin
        rd_addr = TIW'(s_axis_tdata_i[TID_W-1:0]);
        if (s_acc) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        status_d = (kind_q == KIND_REQUEST) ? STATUS_DENIED : STATUS_DONE;
        state_d  = S_DONE;
        case (kind_q)
          KIND_SET_CAPACITY: begin
            if (r_ok) begin
              avail_d[ridx] = amt_clamp;
            end
          end
          KIND_SET_CLAIM: begin
            claim_we = t_ok && r_ok;
          end
          KIND_RELEASE: begin
            if (t_ok) begin
              for (int r = 0; r < RESOURCES; r++) begin
                avail_d[r] = clamp_sum(fit_sum[r]);
              end
              alloc_clr = 1'b1;
            end
          end
          KIND_REQUEST: begin
            if (t_ok && r_ok && avail_q[ridx] != '0 && claim_rd[ridx] > alloc_rd[ridx]) begin
              tent_d       = alloc_rd;
              tent_d[ridx] = alloc_rd[ridx] + UW'(1);
              for (int r = 0; r < RESOURCES; r++) begin
                work_d[r] = WW'(avail_q[r]);
              end
              work_d[ridx] = WW'(avail_q[ridx] - UW'(1));
              done_d  = '0;
              prog_d  = 1'b0;
              cur_d   = '0;
              rd_addr = '0;
              state_d = S_CHECK;
            end
          end
          default: ;
        endcase
      end

      S_CHECK: begin
        rd_addr = cur_next;
        cur_d   = cur_next;
        if (fire) begin
          done_d[cur_q] = 1'b1;
          work_d        = fit_sum;
          prog_d        = 1'b1;
        end
        // end of a pass: all finished means safe, no progress means unsafe
        if (cur_q == TIW'(THREADS - 1)) begin
          prog_d = 1'b0;
          if (&done_d) begin
            alloc_we      = 1'b1;
            grant_w       = 1'b1;
            avail_d[ridx] = avail_q[ridx] - UW'(1);
            status_d      = STATUS_GRANTED;
            state_d       = S_DONE;
          end else if (!(prog_q || fire)) begin
            state_d = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      avail_q   <= '{default: '0};
      done_q    <= '0;
      prog_q    <= 1'b0;
      cur_q     <= '0;
      status_q  <= STATUS_DONE;
      m_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      avail_q  <= avail_d;
      done_q   <= done_d;
      prog_q   <= prog_d;
      cur_q    <= cur_d;
      status_q <= status_d;
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    tent_q <= tent_d;
    if (load_out) begin
      m_status_q <= status_q;
      m_avail_q  <= r_ok ? AVAIL_W'(avail_q[ridx]) : '0;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {(M_TDATA_W - STATUS_W - AVAIL_W)'(0), m_avail_q, m_status_q};

  `BSA_ASSERT_NEXT(a_accept_starts_exec, s_acc, state_q == S_EXEC && !s_axis_tready_o)
  `BSA_ASSERT_NOW(a_scan_in_range, state_q == S_CHECK, 32'(cur_q) < THREADS)
  `BSA_ASSERT_NEXT(a_grant_takes_unit, grant_w, avail_q[ridx] == $past(avail_q[ridx]) - UW'(1))
  `BSA_ASSERT_NEXT(a_result_loaded, load_out, m_axis_tvalid_o && state_q == S_IDLE)

endmodule

// ===== rtl/bsa_row_mem.sv =====
// per-thread row memory with valid bits, one write and one registered read per cycle
module bsa_row_mem #(
  parameter int THREADS   = 8,
  parameter int RESOURCES = 4,
  parameter int UW        = 4,
  parameter int TIW       = (THREADS > 1) ? $clog2(THREADS) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic                          clr_en_i,
  input  logic [TIW-1:0]                wr_addr_i,
  input  logic [RESOURCES-1:0][UW-1:0]  wr_row_i,
  input  logic [TIW-1:0]                rd_addr_i,
  output logic [RESOURCES-1:0][UW-1:0]  rd_row_o
);

  logic [RESOURCES-1:0][UW-1:0] mem_q [THREADS];
  logic [RESOURCES-1:0][UW-1:0] rd_row_q;
  logic [THREADS-1:0]           vld_q;
  logic                         rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_row_i;
    end
    rd_row_q <= mem_q[rd_addr_i];
  end

  // a row never written, or cleared, reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end else if (clr_en_i) begin
        vld_q[wr_addr_i] <= 1'b0;
      end
      rd_vld_q <= vld_q[rd_addr_i];
    end
  end

  assign rd_row_o = rd_vld_q ? rd_row_q : '0;

endmodule

// ===== rtl/bsa_fit_unit.sv =====
// shared row unit: adds a row to the work vector and tests whether the need fits
module bsa_fit_unit #(
  parameter int RESOURCES = 4,
  parameter int UW        = 4,
  parameter int WW        = 8
) (
  input  logic [RESOURCES-1:0][WW-1:0] work_i,
  input  logic [RESOURCES-1:0][UW-1:0] claim_row_i,
  input  logic [RESOURCES-1:0][UW-1:0] alloc_row_i,
  output logic [RESOURCES-1:0][WW-1:0] sum_o,
  output logic                         fits_o
);

  logic [RESOURCES-1:0][WW:0] sum_w;

  // need > work is the same as claim > work + alloc, which avoids negative needs
  always_comb begin
    fits_o = 1'b1;
    for (int r = 0; r < RESOURCES; r++) begin
      sum_w[r] = {1'b0, work_i[r]} + (WW+1)'(alloc_row_i[r]);
      sum_o[r] = sum_w[r][WW-1:0];
      if ((WW+1)'(claim_row_i[r]) > sum_w[r]) begin
        fits_o = 1'b0;
      end
    end
  end

endmodule
